@@ src/rmt_pkg.sv @@
// Shared sizes, codes and handshake structs for the randomized multiset table.
// Depends on nothing; every other file of the block imports it.
package rmt_pkg;
   localparam int MAX_ITEMS   = 256;
   localparam int MAX_KEYS    = 64;
   localparam int MAX_PER_KEY = 16;
   localparam int VALUE_BITS  = 32;

   localparam int IDX_W  = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int KEY_W  = $clog2(MAX_KEYS);
   localparam int SLOT_W = $clog2(MAX_PER_KEY);
   localparam int USE_W  = $clog2(MAX_PER_KEY + 1);
   localparam int POS_W  = KEY_W + SLOT_W;
   localparam int DRAW_W = 16;
   localparam int DIV_STEP_W = $clog2(DRAW_W + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_SAMPLE = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic              start;
      logic [DRAW_W-1:0] dividend;
      logic [CNT_W-1:0]  divisor;
   } rmt_div_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] remainder;
   } rmt_div_rsp_type;
endpackage

@@ src/randomized_multiset_table.sv @@
// Top level of the randomized multiset table: sequencer, key, position and
// item memories, and the output register. Depends on rmt_pkg and rmt_mod.
//
//  channel  direction  tdata / tuser
//  req_     in         tdata: value[31:0], draw[47:32]; tuser: cmd[1:0]
//  rsp_     out        tdata: ok[0], sampled_value[32:1], status[34:33],
//                             item_total[43:35], zero fill [47:44]
//
// Insert and remove sweep the key memory once, one key per cycle, then decide;
// a remove whose key is found adds a read-modify-write state.
// A sample runs the 16-step modulo unit and then reads the item memory.
// Other commands go straight to the reply.
// Reset clears the item count and the key valid bits; no clearing pass runs.
// A new word is taken while the previous result still waits on rsp_.
module randomized_multiset_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // value[31:0], draw[47:32]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // ok, sampled_value, status, item_total, fill
);
   import rmt_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SEARCH   = 8'b0000_0010,
      ST_DECIDE   = 8'b0000_0100,
      ST_RM_WRITE = 8'b0000_1000,
      ST_DIV      = 8'b0001_0000,
      ST_SMP_DATA = 8'b0010_0000,
      ST_REPLY    = 8'b0100_0000,
      ST_DIV_WAIT = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [USE_W-1:0]      uses;
   } key_entry_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [SLOT_W-1:0]     slot;
      logic [KEY_W-1:0]      key;
   } item_entry_type;

   key_entry_type  key_mem  [MAX_KEYS];
   logic [IDX_W-1:0] pos_mem [MAX_KEYS*MAX_PER_KEY];
   item_entry_type item_mem [MAX_ITEMS];

   state_type state_ff, state_in;
   logic [MAX_KEYS-1:0] kvalid_ff, kvalid_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic [1:0]            cmd_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [DRAW_W-1:0]     draw_ff;

   logic [KEY_W:0]     scan_ff, scan_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [KEY_W-1:0]   chk_ff, chk_in;
   logic               hit_ff, hit_in;
   logic [KEY_W-1:0]   hitk_ff, hitk_in;
   logic [USE_W-1:0]   uses_ff, uses_in;
   logic               free_ff, free_in;
   logic [KEY_W-1:0]   freek_ff, freek_in;

   logic                  res_ok_ff, res_ok_in;
   logic [VALUE_BITS-1:0] res_smp_ff, res_smp_in;
   logic [1:0]            res_st_ff, res_st_in;

   logic        out_vld_ff, out_vld_in;
   logic [47:0] out_data_ff, out_data_in;

   key_entry_type  key_rd_ff;
   logic [IDX_W-1:0] pos_rd_ff;
   item_entry_type item_rd_ff;

   logic [KEY_W-1:0]  key_raddr;
   logic [POS_W-1:0]  pos_raddr;
   logic [IDX_W-1:0]  item_raddr;

   logic              key_we;
   logic [KEY_W-1:0]  key_waddr;
   key_entry_type     key_wdata;
   logic              pos_we;
   logic [POS_W-1:0]  pos_waddr;
   logic [IDX_W-1:0]  pos_wdata;
   logic              item_we;
   logic [IDX_W-1:0]  item_waddr;
   item_entry_type    item_wdata;

   logic              accept;
   logic              fresh;
   logic [KEY_W-1:0]  ins_key;
   logic [USE_W-1:0]  ins_pos;
   logic [USE_W-1:0]  rm_n;
   logic [IDX_W-1:0]  last_idx;

   rmt_div_req_type div_req;
   rmt_div_rsp_type div_rsp;

   rmt_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   assign fresh    = !hit_ff;
   assign ins_key  = hit_ff ? hitk_ff : freek_ff;
   assign ins_pos  = hit_ff ? uses_ff : '0;
   assign rm_n     = uses_ff - 1'b1;
   assign last_idx = IDX_W'(count_ff - 1'b1);

   always_comb begin
      state_in   = state_ff;
      kvalid_in  = kvalid_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      chk_vld_in = 1'b0;
      chk_in     = chk_ff;
      hit_in     = hit_ff;
      hitk_in    = hitk_ff;
      uses_in    = uses_ff;
      free_in    = free_ff;
      freek_in   = freek_ff;
      res_ok_in  = res_ok_ff;
      res_smp_in = res_smp_ff;
      res_st_in  = res_st_ff;
      out_vld_in  = out_vld_ff;
      out_data_in = out_data_ff;

      key_raddr  = scan_ff[KEY_W-1:0];
      // Key slots and list slots are powers of two, so the list address is a join.
      pos_raddr  = {hitk_ff, rm_n[SLOT_W-1:0]};
      item_raddr = last_idx;

      key_we     = 1'b0;
      key_waddr  = ins_key;
      key_wdata  = '{value: val_ff, uses: USE_W'(ins_pos + 1'b1)};
      pos_we     = 1'b0;
      pos_waddr  = {ins_key, ins_pos[SLOT_W-1:0]};
      pos_wdata  = count_ff[IDX_W-1:0];
      item_we    = 1'b0;
      item_waddr = count_ff[IDX_W-1:0];
      item_wdata = '{value: val_ff, slot: ins_pos[SLOT_W-1:0], key: ins_key};

      div_req.start    = 1'b0;
      div_req.dividend = draw_ff;
      div_req.divisor  = count_ff;

      if (rsp_tready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_ok_in  = 1'b0;
               res_smp_in = '0;
               res_st_in  = STATUS_DONE;
               scan_in    = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               if (req_tuser == CMD_INSERT || req_tuser == CMD_REMOVE) begin
                  state_in = ST_SEARCH;
               end else if (req_tuser == CMD_SAMPLE) begin
                  if (count_ff == '0) begin
                     res_st_in = STATUS_EMPTY;
                     state_in  = ST_REPLY;
                  end else begin
                     state_in = ST_DIV;
                  end
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_SEARCH: begin
            if (scan_ff < (KEY_W+1)'(MAX_KEYS)) begin
               scan_in    = scan_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_in     = scan_ff[KEY_W-1:0];
            end
            // Read data of the slot issued last cycle; keep the first match and
            // the first free slot.
            if (chk_vld_ff) begin
               if (kvalid_ff[chk_ff] && key_rd_ff.value == val_ff && !hit_ff) begin
                  hit_in  = 1'b1;
                  hitk_in = chk_ff;
                  uses_in = key_rd_ff.uses;
               end
               if (!kvalid_ff[chk_ff] && !free_ff) begin
                  free_in  = 1'b1;
                  freek_in = chk_ff;
               end
               if (chk_ff == KEY_W'(MAX_KEYS - 1)) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (cmd_ff == CMD_INSERT) begin
               if (count_ff >= CNT_W'(MAX_ITEMS) || (fresh && !free_ff) ||
                   (!fresh && uses_ff >= USE_W'(MAX_PER_KEY))) begin
                  res_st_in = STATUS_FULL;
               end else begin
                  key_we  = 1'b1;
                  pos_we  = 1'b1;
                  item_we = 1'b1;
                  kvalid_in[ins_key] = 1'b1;
                  count_in  = count_ff + 1'b1;
                  res_ok_in = fresh;
               end
               state_in = ST_REPLY;
            end else begin
               // Remove: list and last-item reads go out here when the key exists.
               if (hit_ff && count_ff != '0) begin
                  state_in = ST_RM_WRITE;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_RM_WRITE: begin
            key_we    = 1'b1;
            key_waddr = hitk_ff;
            key_wdata = '{value: val_ff, uses: rm_n};
            if (rm_n == '0) begin
               kvalid_in[hitk_ff] = 1'b0;
            end
            if (pos_rd_ff != last_idx) begin
               item_we    = 1'b1;
               item_waddr = pos_rd_ff;
               item_wdata = item_rd_ff;
               pos_we     = 1'b1;
               pos_waddr  = {item_rd_ff.key, item_rd_ff.slot};
               pos_wdata  = pos_rd_ff;
            end
            count_in  = count_ff - 1'b1;
            res_ok_in = 1'b1;
            state_in  = ST_REPLY;
         end
         ST_DIV: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            item_raddr = div_rsp.remainder[IDX_W-1:0];
            if (div_rsp.done) begin
               state_in = ST_SMP_DATA;
            end
         end
         ST_SMP_DATA: begin
            res_smp_in = item_rd_ff.value;
            state_in   = ST_REPLY;
         end
         ST_REPLY: begin
            if (!out_vld_ff || rsp_tready) begin
               out_vld_in  = 1'b1;
               out_data_in = {4'b0, count_ff, res_st_ff, res_smp_ff, res_ok_ff};
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         kvalid_ff  <= '0;
         count_ff   <= '0;
         out_vld_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         kvalid_ff  <= kvalid_in;
         count_ff   <= count_in;
         out_vld_ff <= out_vld_in;
         chk_vld_ff <= chk_vld_in;
      end
      if (accept) begin
         cmd_ff  <= req_tuser;
         val_ff  <= req_tdata[VALUE_BITS-1:0];
         draw_ff <= req_tdata[47:32];
      end
      scan_ff     <= scan_in;
      chk_ff      <= chk_in;
      hit_ff      <= hit_in;
      hitk_ff     <= hitk_in;
      uses_ff     <= uses_in;
      free_ff     <= free_in;
      freek_ff    <= freek_in;
      res_ok_ff   <= res_ok_in;
      res_smp_ff  <= res_smp_in;
      res_st_ff   <= res_st_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rd_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (item_we) begin
         item_mem[item_waddr] <= item_wdata;
      end
      item_rd_ff <= item_mem[item_raddr];
   end
endmodule

@@ src/rmt_mod.sv @@
// Restoring modulo unit: one remainder bit per cycle for the sample index.
// Depends on rmt_pkg.
module rmt_mod (
   input  logic                     clock,
   input  logic                     reset,
   input  rmt_pkg::rmt_div_req_type req,
   output rmt_pkg::rmt_div_rsp_type rsp
);
   import rmt_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DRAW_W-1:0]     dvd_ff, dvd_in;
   logic [CNT_W-1:0]      dsr_ff, dsr_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W:0]        trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[DRAW_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits CNT_W bits.
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         dvd_in  = {dvd_ff[DRAW_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DRAW_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;
endmodule
